@@ src/npd_pkg.sv @@
// Shared types and constants for the nearest-point LLR demapper.
// No dependencies; imported by npd_ram users and the top level.
package npd_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DATA_W      = 16;
    localparam int DIST_W      = DATA_W + 1;

    localparam logic [CNT_W-1:0] PIU_RESET = CNT_W'(TABLE_DEPTH);

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_DEMAP = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_BELOW,
        ST_ABOVE,
        ST_LLR
    } state_t;

endpackage

@@ src/npd_ram.sv @@
// Simple dual-port synchronous RAM, one write port and one read port.
// Read data is registered: rdata shows the word at raddr in the cycle after. No package dependency.
module npd_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/nearest_point_llr_demapper_unit.sv @@
// Top level of the nearest-point LLR demapper: request FSM, binary search
// and the point/LLR table memories. Depends on npd_pkg and npd_ram.
//
// Usage
//   Requests are taken on start while busy is low. A write request
//   (req_type 0) stores point_value and entry_llr at entry_index in the
//   same edge and leaves busy low; writes go at one per cycle while idle.
//   A demap request (req_type 1) runs a lower-bound binary search over the
//   first points_in_use points of the table, one memory read per step,
//   then reads the two neighbours (when needed) and the chosen entry's LLR.
//   The result (llr, nearest_index, frame_end) is shown for one cycle with
//   done high; the receiver cannot stall, so it must take it then.
//   Steps from accept to done: the search reads, two neighbour reads when
//   the sample falls between points, the LLR read and the output register.
//   The single read port of the point memory sets the pace.
//   A new request is accepted in the cycle done is high.
//   cfg_data (points_in_use) is written when cfg_valid is high; cfg_ready
//   is always high. Reset returns the FSM to idle and points_in_use to
//   1024; the table contents are undefined until written.
module nearest_point_llr_demapper_unit
    import npd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     req_type,
    input  logic [IDX_W-1:0]         entry_index,
    input  logic signed [DATA_W-1:0] point_value,
    input  logic signed [DATA_W-1:0] entry_llr,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     last_in_frame,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CNT_W-1:0]         cfg_data,
    output logic                     done,
    output logic signed [DATA_W-1:0] llr,
    output logic [IDX_W-1:0]         nearest_index,
    output logic                     frame_end
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]         piu_reg;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic signed [DATA_W-1:0] below_reg, below_next;
    logic signed [DATA_W-1:0] sample_reg;
    logic                     last_reg;
    logic signed [DATA_W-1:0] llr_reg, llr_next;
    logic                     done_reg, done_next;

    logic                     accept;
    logic                     tbl_we;
    logic [IDX_W-1:0]         pt_raddr, llr_raddr;
    logic [DATA_W-1:0]        pt_rdata, llr_rdata;

    logic [CNT_W-1:0]         eff_cnt;
    logic [CNT_W-1:0]         step;
    logic                     probe_lt;
    logic [CNT_W-1:0]         lo_upd, cnt_upd;
    logic [CNT_W-1:0]         probe_sum;
    logic signed [DIST_W-1:0] dist_lo, dist_hi;

    assign accept    = start && !busy;
    assign tbl_we    = accept && (req_type == REQ_WRITE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    npd_ram #(.ADDR_W(IDX_W), .DATA_W(DATA_W)) u_point_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (entry_index),
        .wdata (point_value),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    npd_ram #(.ADDR_W(IDX_W), .DATA_W(DATA_W)) u_llr_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (entry_index),
        .wdata (entry_llr),
        .raddr (llr_raddr),
        .rdata (llr_rdata)
    );

    // zero counts as one, anything above the table depth saturates
    always_comb
    begin
        if (piu_reg == '0)
        begin
            eff_cnt = CNT_W'(1);
        end
        else if (piu_reg > PIU_RESET)
        begin
            eff_cnt = PIU_RESET;
        end
        else
        begin
            eff_cnt = piu_reg;
        end
    end

    // one lower-bound step on the probe read issued last cycle
    always_comb
    begin
        step     = cnt_reg >> 1;
        probe_lt = ($signed(pt_rdata) < sample_reg);
        if (probe_lt)
        begin
            lo_upd  = lo_reg + step + CNT_W'(1);
            cnt_upd = cnt_reg - step - CNT_W'(1);
        end
        else
        begin
            lo_upd  = lo_reg;
            cnt_upd = step;
        end
        probe_sum = lo_upd + (cnt_upd >> 1);
    end

    assign dist_lo = {sample_reg[DATA_W-1], sample_reg} - {below_reg[DATA_W-1], below_reg};
    assign dist_hi = {pt_rdata[DATA_W-1], pt_rdata} - {sample_reg[DATA_W-1], sample_reg};

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        below_next = below_reg;
        llr_next   = llr_reg;
        done_next  = 1'b0;
        pt_raddr   = '0;
        llr_raddr  = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_DEMAP))
                begin
                    lo_next    = '0;
                    cnt_next   = eff_cnt;
                    pt_raddr   = IDX_W'(eff_cnt >> 1);
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                lo_next  = lo_upd;
                cnt_next = cnt_upd;
                if (cnt_upd == '0)
                begin
                    if (lo_upd >= eff_cnt)
                    begin
                        idx_next   = IDX_W'(eff_cnt - CNT_W'(1));
                        llr_raddr  = IDX_W'(eff_cnt - CNT_W'(1));
                        state_next = ST_LLR;
                    end
                    else if (lo_upd == '0)
                    begin
                        idx_next   = '0;
                        llr_raddr  = '0;
                        state_next = ST_LLR;
                    end
                    else
                    begin
                        pt_raddr   = IDX_W'(lo_upd - CNT_W'(1));
                        state_next = ST_BELOW;
                    end
                end
                else
                begin
                    pt_raddr = IDX_W'(probe_sum);
                end
            end
            ST_BELOW:
            begin
                below_next = $signed(pt_rdata);
                pt_raddr   = lo_reg[IDX_W-1:0];
                state_next = ST_ABOVE;
            end
            ST_ABOVE:
            begin
                // a tie goes to the upper point
                if (dist_lo < dist_hi)
                begin
                    idx_next  = IDX_W'(lo_reg - CNT_W'(1));
                    llr_raddr = IDX_W'(lo_reg - CNT_W'(1));
                end
                else
                begin
                    idx_next  = lo_reg[IDX_W-1:0];
                    llr_raddr = lo_reg[IDX_W-1:0];
                end
                state_next = ST_LLR;
            end
            ST_LLR:
            begin
                llr_next   = $signed(llr_rdata);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            piu_reg   <= PIU_RESET;
            lo_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            lo_reg    <= lo_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                piu_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        below_reg <= below_next;
        llr_reg   <= llr_next;
        if (accept)
        begin
            sample_reg <= sample;
            last_reg   <= last_in_frame;
        end
    end

    assign done          = done_reg;
    assign llr           = llr_reg;
    assign nearest_index = idx_reg;
    assign frame_end     = last_reg;

`ifndef SYNTHESIS
    a_done_after_llr: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_LLR))
        else $error("result strobe without an LLR read");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_search_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (cnt_reg != '0))
        else $error("search step with an empty span");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, nearest_index} < eff_cnt))
        else $error("nearest index beyond the searched points");
`endif

endmodule
